[rtl/pdld_pkg.sv]
// pdld_pkg: shared widths, constants, codes and handshake structs for the
// line-follow PD drive core. Used by pdld_mul, pdld_div and the top level.
// No dependencies.
package pdld_pkg;

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int DT_W = 24;
	localparam int GAIN_W = 16;
	localparam int LEVEL_W = 12;
	localparam int LIM_W = 15;
	localparam int RAMP_W = 9;
	localparam int SPEED_W = 15;
	localparam int CORR_W = 16;
	localparam int ERR_W = 13;
	localparam int CHG_W = 14;

	// control constants
	localparam int FIRST_DT_US = 10000;
	localparam int DERIV_LIMIT = 1000;
	localparam int DERIV_W = $clog2(DERIV_LIMIT + 1);
	localparam int SPEED_MAX = 20480;
	localparam int RAMP_ONE = 256;
	localparam int SAMPLE_RESET = 700;
	localparam int DT_SCALE = 1000000;

	// shared multiplier and divider sizes
	localparam int MUL_A_W = 17;
	localparam int MUL_B_W = 21;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int ACC_W = 31;
	localparam int NUM_W = 33;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_GAIN_P = 3'd0,
		CFG_GAIN_D = 3'd1,
		CFG_TARGET = 3'd2,
		CFG_CORR_LIM = 3'd3,
		CFG_BASE_L = 3'd4,
		CFG_BASE_R = 3'd5,
		CFG_WHITE = 3'd6,
		CFG_RAMP_STEP = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULC,
		ST_DIVI,
		ST_DIV,
		ST_MULP,
		ST_MULD,
		ST_SUM,
		ST_CLMP,
		ST_MULR,
		ST_RAMP,
		ST_OUT
	} pdld_state_t;

	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic start;
		logic [NUM_W-1:0] num;
		logic [DT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DERIV_W-1:0] quot;
	} div_rsp_t;

endpackage

[rtl/pdld_mul.sv]
// pdld_mul: shared signed multiplier with a registered product.
// Depends on pdld_pkg.
module pdld_mul (
	input  logic               clk,
	input  pdld_pkg::mul_req_t req,
	output logic signed [pdld_pkg::MUL_P_W-1:0] prod
);
	import pdld_pkg::*;

	logic signed [MUL_P_W-1:0] prod_q;

	// one product per cycle, result in the following cycle
	always_ff @(posedge clk) begin
		prod_q <= req.a * req.b;
	end

	assign prod = prod_q;

endmodule

[rtl/pdld_div.sv]
// pdld_div: bit-serial restoring divider, one quotient bit per cycle,
// quotient saturated to the derivative limit. Depends on pdld_pkg.
module pdld_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pdld_pkg::div_req_t req,
	output pdld_pkg::div_rsp_t rsp
);
	import pdld_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     num_q;
	logic [DT_W-1:0]      den_q;
	logic [DT_W-1:0]      rem_q;
	logic [DERIV_W:0]     quo_q;
	logic                 ovf_q;
	logic [DT_W:0]        rem_sh;
	logic [DT_W:0]        rem_diff;
	logic                 fits;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		fits = rem_sh >= {1'b0, den_q};
		rem_diff = rem_sh - {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? rem_diff[DT_W-1:0] : rem_sh[DT_W-1:0];
			quo_q <= {quo_q[DERIV_W-1:0], fits};
			ovf_q <= ovf_q | quo_q[DERIV_W];
		end
	end

	// saturated quotient
	always_comb begin
		rsp.done = done_q;
		if (ovf_q || quo_q > (DERIV_W + 1)'(DERIV_LIMIT)) begin
			rsp.quot = DERIV_W'(DERIV_LIMIT);
		end else begin
			rsp.quot = quo_q[DERIV_W-1:0];
		end
	end

endmodule

[rtl/pd_line_follow_drive_core.sv]
// pd_line_follow_drive_core: PD line follower for a differential drive, one
// result item per sample item. Depends on pdld_pkg, pdld_mul and pdld_div.
//
// Each input item (IR sample, elapsed microseconds) yields one result item
// (left and right drive in unsigned Q7.8 percent, applied correction in
// signed Q8.8 percent). One item is worked at a time: s_axis_tready is
// high only while the sequencer is idle. When the error changed and the
// elapsed time is nonzero, the 33-step bit-serial divider forms the
// derivative; otherwise the divider is skipped. A white sample adds the
// ramp multiply, and a result that is not yet taken holds the sequencer
// in its output step. All products go through one registered 17x21
// multiplier. A finished result waits in the output register while the
// next item is accepted. Configuration writes are taken on any cycle with
// cfg_we high and should only be issued while the block is idle.
module pd_line_follow_drive_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [pdld_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [pdld_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// sample items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // ir_sample[11:0], elapsed_us[35:12], zero
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // left_drive[14:0], right_drive[29:15],
	                                   // applied_correction[45:30], zero
);
	import pdld_pkg::*;

	// configuration registers
	logic [GAIN_W-1:0]  gain_p_q;
	logic [GAIN_W-1:0]  gain_d_q;
	logic [LEVEL_W-1:0] target_q;
	logic [LIM_W-1:0]   corr_lim_q;
	logic [LIM_W-1:0]   base_l_q;
	logic [LIM_W-1:0]   base_r_q;
	logic [LEVEL_W-1:0] white_q;
	logic [RAMP_W-1:0]  ramp_step_q;

	// loop state
	logic signed [ERR_W-1:0]  last_err_q;
	logic signed [CORR_W-1:0] last_corr_q;
	logic [SAMPLE_W-1:0]      last_sample_q;
	logic [RAMP_W-1:0]        ramp_q;
	logic                     started_q;

	// per-item work registers
	pdld_state_t state_q, state_d;
	logic [SAMPLE_W-1:0]       sample_q;
	logic [DT_W-1:0]           dt_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [CHG_W-1:0]   chg_q;
	logic signed [DERIV_W:0]   deriv_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [CORR_W-1:0]  corr_q;

	// output register
	logic                      out_valid_q;
	logic [SPEED_W-1:0]        left_q;
	logic [SPEED_W-1:0]        right_q;
	logic signed [CORR_W-1:0]  out_corr_q;

	// shared units
	mul_req_t mul_req;
	logic signed [MUL_P_W-1:0] prod;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// combinational helpers
	logic [SAMPLE_W-1:0]        in_sample;
	logic [DT_W-1:0]            in_dt;
	logic                       in_fire;
	logic                       out_free;
	logic signed [ERR_W-1:0]    err_new;
	logic signed [CHG_W-1:0]    chg_new;
	logic [CHG_W-1:0]           chg_mag;
	logic signed [ACC_W-9:0]    pd_shift;
	logic signed [ACC_W-9:0]    lim_ext;
	logic signed [CORR_W-1:0]   corr_clamp;
	logic signed [CORR_W-1:0]   corr_new;
	logic                       hold;
	logic                       white;
	logic [RAMP_W:0]            ramp_sum;
	logic signed [SPEED_W+2:0]  left_raw;
	logic signed [SPEED_W+2:0]  right_raw;
	logic [SPEED_W-1:0]         left_sat;
	logic [SPEED_W-1:0]         right_sat;

	assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
	assign in_dt = s_axis_tdata[SAMPLE_W+DT_W-1:SAMPLE_W];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	pdld_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	pdld_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= GAIN_W'(983);
			gain_d_q <= GAIN_W'(459);
			target_q <= LEVEL_W'(700);
			corr_lim_q <= LIM_W'(2688);
			base_l_q <= LIM_W'(6848);
			base_r_q <= LIM_W'(6400);
			white_q <= LEVEL_W'(300);
			ramp_step_q <= RAMP_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_GAIN_P: gain_p_q <= cfg_wdata[GAIN_W-1:0];
				CFG_GAIN_D: gain_d_q <= cfg_wdata[GAIN_W-1:0];
				CFG_TARGET: target_q <= cfg_wdata[LEVEL_W-1:0];
				CFG_CORR_LIM: corr_lim_q <= cfg_wdata[LIM_W-1:0];
				CFG_BASE_L: base_l_q <= cfg_wdata[LIM_W-1:0];
				CFG_BASE_R: base_r_q <= cfg_wdata[LIM_W-1:0];
				CFG_WHITE: white_q <= cfg_wdata[LEVEL_W-1:0];
				CFG_RAMP_STEP: ramp_step_q <= cfg_wdata[RAMP_W-1:0];
				default: ;
			endcase
		end
	end

	// error and change for the incoming sample
	always_comb begin
		err_new = $signed({1'b0, target_q}) - $signed({1'b0, in_sample});
		chg_new = CHG_W'(err_new) - CHG_W'(last_err_q);
		chg_mag = chg_q[CHG_W-1] ? CHG_W'(-chg_q) : chg_q;
	end

	// PD clamp, crossing hold, white ramp
	always_comb begin
		pd_shift = acc_q[ACC_W-1:8];
		lim_ext = $signed({{(ACC_W - 8 - LIM_W){1'b0}}, corr_lim_q});
		if (pd_shift > lim_ext) begin
			corr_clamp = CORR_W'(lim_ext);
		end else if (pd_shift < -lim_ext) begin
			corr_clamp = CORR_W'(-lim_ext);
		end else begin
			corr_clamp = CORR_W'(pd_shift);
		end
		hold = (sample_q > target_q) && (last_sample_q < target_q);
		corr_new = hold ? last_corr_q : corr_clamp;
		white = sample_q < white_q;
		ramp_sum = {1'b0, ramp_q} + {1'b0, ramp_step_q};
	end

	// differential speeds
	always_comb begin
		left_raw = $signed({3'b000, base_l_q}) - (SPEED_W + 3)'(corr_q);
		right_raw = $signed({3'b000, base_r_q}) + (SPEED_W + 3)'(corr_q);
		if (left_raw < 0) begin
			left_sat = '0;
		end else if (left_raw > (SPEED_W + 3)'(SPEED_MAX)) begin
			left_sat = SPEED_W'(SPEED_MAX);
		end else begin
			left_sat = left_raw[SPEED_W-1:0];
		end
		if (right_raw < 0) begin
			right_sat = '0;
		end else if (right_raw > (SPEED_W + 3)'(SPEED_MAX)) begin
			right_sat = SPEED_W'(SPEED_MAX);
		end else begin
			right_sat = right_raw[SPEED_W-1:0];
		end
	end

	// multiplier operand select
	always_comb begin
		mul_req.a = '0;
		mul_req.b = '0;
		unique case (state_q)
			ST_MULC: begin
				mul_req.a = $signed({{(MUL_A_W - CHG_W){1'b0}}, chg_mag});
				mul_req.b = MUL_B_W'(DT_SCALE);
			end
			ST_MULP: begin
				mul_req.a = $signed({1'b0, gain_p_q});
				mul_req.b = MUL_B_W'(err_q);
			end
			ST_MULD: begin
				mul_req.a = $signed({1'b0, gain_d_q});
				mul_req.b = MUL_B_W'(deriv_q);
			end
			ST_MULR: begin
				mul_req.a = MUL_A_W'(corr_q);
				mul_req.b = $signed({{(MUL_B_W - RAMP_W){1'b0}}, ramp_q});
			end
			default: ;
		endcase
	end

	// divider request
	always_comb begin
		div_req.start = (state_q == ST_DIVI) && (chg_q != '0) && (dt_q != '0);
		div_req.num = prod[NUM_W-1:0];
		div_req.den = dt_q;
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_MULC;
			ST_MULC: state_d = ST_DIVI;
			ST_DIVI: state_d = div_req.start ? ST_DIV : ST_MULP;
			ST_DIV: if (div_rsp.done) state_d = ST_MULP;
			ST_MULP: state_d = ST_MULD;
			ST_MULD: state_d = ST_SUM;
			ST_SUM: state_d = ST_CLMP;
			ST_CLMP: state_d = white ? ST_MULR : ST_OUT;
			ST_MULR: state_d = ST_RAMP;
			ST_RAMP: state_d = ST_OUT;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// per-item datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					sample_q <= in_sample;
					dt_q <= started_q ? in_dt : DT_W'(FIRST_DT_US);
					err_q <= err_new;
					chg_q <= chg_new;
				end
			end
			ST_DIVI: begin
				if (chg_q == '0) begin
					deriv_q <= '0;
				end else if (dt_q == '0) begin
					deriv_q <= chg_q[CHG_W-1] ? -(DERIV_W + 1)'(DERIV_LIMIT)
					                          : (DERIV_W + 1)'(DERIV_LIMIT);
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					deriv_q <= chg_q[CHG_W-1] ? -$signed({1'b0, div_rsp.quot})
					                          : $signed({1'b0, div_rsp.quot});
				end
			end
			ST_MULD: acc_q <= prod[ACC_W-1:0];
			ST_SUM: acc_q <= acc_q + prod[ACC_W-1:0];
			ST_CLMP: corr_q <= corr_new;
			ST_RAMP: corr_q <= prod[CORR_W+7:8];
			default: ;
		endcase
	end

	// loop state update at the end of the PD step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			last_corr_q <= '0;
			last_sample_q <= SAMPLE_W'(SAMPLE_RESET);
			ramp_q <= '0;
			started_q <= 1'b0;
		end else if (state_q == ST_CLMP) begin
			last_err_q <= err_q;
			last_corr_q <= corr_new;
			last_sample_q <= sample_q;
			started_q <= 1'b1;
			if (!white) begin
				ramp_q <= '0;
			end else if (ramp_sum > (RAMP_W + 1)'(RAMP_ONE)) begin
				ramp_q <= RAMP_W'(RAMP_ONE);
			end else begin
				ramp_q <= ramp_sum[RAMP_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			left_q <= left_sat;
			right_q <= right_sat;
			out_corr_q <= corr_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {2'b00, out_corr_q, right_q, left_q};

	// checks
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_ramp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q <= RAMP_W'(RAMP_ONE))
		else $error("ramp factor above one");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("result item raised without the output step");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> left_q <= SPEED_W'(SPEED_MAX) && right_q <= SPEED_W'(SPEED_MAX))
		else $error("motor speed above limit");

	a_deriv_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MULD |-> deriv_q <= (DERIV_W + 1)'(DERIV_LIMIT)
		&& deriv_q >= -(DERIV_W + 1)'(DERIV_LIMIT))
		else $error("derivative outside clamp");

endmodule

[sim/pd_line_follow_drive_core_tb.sv]
// pd_line_follow_drive_core_tb: self-checking bench for the PD line-follow drive core.
// It predicts the motor speeds and the applied correction for every accepted sample item.
// It runs directed and random stimulus under several register setups. Depends on pdld_pkg.
module pd_line_follow_drive_core_tb;
	import pdld_pkg::*;

	localparam int ITEMS_PER_SETUP = 95;
	localparam int SETUP_COUNT = 10;
	localparam int SETTLE_CYCLES = 60;
	localparam int TIMEOUT_UNITS = 7200000;

	// one predicted result item
	typedef struct {
		logic [SPEED_W-1:0] left;
		logic [SPEED_W-1:0] right;
		logic [CORR_W-1:0] corr;
	} drive_item_t;

	// shadow registers, controller state and the queue of pending drive items
	class drive_scoreboard;
		int gain_p, gain_d, target, corr_lim, base_l, base_r, white, ramp_step;
		longint last_err, last_corr;
		int last_sample, ramp;
		bit started;
		drive_item_t pending_drive[$];
		int errors;

		function new();
			gain_p = 983; gain_d = 459; target = SAMPLE_RESET; corr_lim = 2688;
			base_l = 6848; base_r = 6400; white = 300; ramp_step = 32;
			last_err = 0; last_corr = 0; last_sample = SAMPLE_RESET;
			ramp = 0; started = 0; errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				CFG_GAIN_P: gain_p = int'(v);
				CFG_GAIN_D: gain_d = int'(v);
				CFG_TARGET: target = int'(v[LEVEL_W-1:0]);
				CFG_CORR_LIM: corr_lim = int'(v[LIM_W-1:0]);
				CFG_BASE_L: base_l = int'(v[LIM_W-1:0]);
				CFG_BASE_R: base_r = int'(v[LIM_W-1:0]);
				CFG_WHITE: white = int'(v[LEVEL_W-1:0]);
				CFG_RAMP_STEP: ramp_step = int'(v[RAMP_W-1:0]);
				default: ;
			endcase
		endfunction

		// work out the drive item that one accepted sample item causes
		function void note_sample(logic [SAMPLE_W-1:0] sample, logic [DT_W-1:0] dt);
			longint err, chg, deriv, corr, mag, dtv, lft, rgt;
			int smp;
			drive_item_t it;
			smp = int'(sample);
			dtv = started ? longint'(dt) : longint'(FIRST_DT_US);
			err = longint'(target) - longint'(smp);
			chg = err - last_err;
			// derivative of the error, saturated
			if (chg == 0) begin
				deriv = 0;
			end else if (dtv == 0) begin
				deriv = (chg > 0) ? DERIV_LIMIT : -DERIV_LIMIT;
			end else begin
				mag = ((chg > 0) ? chg : -chg) * DT_SCALE / dtv;
				if (mag > DERIV_LIMIT)
					mag = DERIV_LIMIT;
				deriv = (chg > 0) ? mag : -mag;
			end
			corr = (longint'(gain_p) * err + longint'(gain_d) * deriv) >>> 8;
			if (corr > corr_lim)
				corr = corr_lim;
			if (corr < -corr_lim)
				corr = -corr_lim;
			// rising crossing of the target holds the previous correction
			if (smp > target && last_sample < target)
				corr = last_corr;
			last_corr = corr;
			last_err = err;
			last_sample = smp;
			started = 1;
			// white surface ramps the correction in
			if (smp < white) begin
				ramp = ramp + ramp_step;
				if (ramp > RAMP_ONE)
					ramp = RAMP_ONE;
				corr = (corr * longint'(ramp)) >>> 8;
			end else begin
				ramp = 0;
			end
			lft = longint'(base_l) - corr;
			rgt = longint'(base_r) + corr;
			if (lft < 0) lft = 0;
			if (lft > SPEED_MAX) lft = SPEED_MAX;
			if (rgt < 0) rgt = 0;
			if (rgt > SPEED_MAX) rgt = SPEED_MAX;
			it.left = lft[SPEED_W-1:0];
			it.right = rgt[SPEED_W-1:0];
			it.corr = corr[CORR_W-1:0];
			pending_drive.push_back(it);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d want %0d", what, got, want);
			errors++;
		endtask

		// compare one accepted result item with the oldest prediction
		task check_result(logic [47:0] data);
			drive_item_t want;
			if (pending_drive.size() == 0) begin
				report("unexpected item", longint'(data), 0);
			end else begin
				want = pending_drive.pop_front();
				if (data[14:0] !== want.left)
					report("left_drive", data[14:0], want.left);
				if (data[29:15] !== want.right)
					report("right_drive", data[29:15], want.right);
				if (data[45:30] !== want.corr)
					report("applied_correction", $signed(data[45:30]), $signed(want.corr));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // ir_sample[11:0], elapsed_us[35:12], zero
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;       // left_drive[14:0], right_drive[29:15],
	                                 // applied_correction[45:30], zero

	int src_idle_pct = 38;
	int sink_stall_pct = 72;
	int prev_sample = SAMPLE_RESET;
	drive_scoreboard sb = new();

	pd_line_follow_drive_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #6 clk = ~clk;

	// receiver stalls at random
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// watch both handshakes
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			sb.note_sample(s_axis_tdata[11:0], s_axis_tdata[35:12]);
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// offer one sample item, idling at random first
	task automatic send_sample(input int sample, input logic [DT_W-1:0] dt);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, dt, sample[SAMPLE_W-1:0]};
		prev_sample = sample;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop sending and let the block drain
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write; the caller drops the write enable after the last one
	task automatic write_reg(input cfg_idx_t idx, input int value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		sb.set_reg(idx, value[CFG_DATA_W-1:0]);
	endtask

	// load one register setup: reset values, all high, all low, or random
	task automatic load_setup(input int kind);
		int v[8];
		case (kind)
			0: v = '{983, 459, 700, 2688, 6848, 6400, 300, 32};
			1: v = '{65535, 65535, 4095, 25600, 25600, 25600, 4095, 256};
			2: v = '{0, 0, 0, 0, 0, 0, 0, 0};
			default: begin
				v[0] = $urandom_range(0, 65535);
				v[1] = $urandom_range(0, 65535);
				v[2] = $urandom_range(0, 4095);
				v[3] = $urandom_range(0, 25600);
				v[4] = $urandom_range(0, 25600);
				v[5] = $urandom_range(0, 25600);
				v[6] = $urandom_range(0, 4095);
				v[7] = ($urandom_range(1) == 1) ? $urandom_range(1, 40) : $urandom_range(0, 256);
			end
		endcase
		for (int i = 0; i < 8; i++)
			write_reg(cfg_idx_t'(i), v[i]);
		cfg_we <= 1'b0;
	endtask

	// random samples: near the line edge most often, with repeats, white runs and noise
	task automatic play_random(input int count);
		int pick, s;
		logic [DT_W-1:0] d;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				s = sb.target + $urandom_range(0, 80) - 40;
			else if (pick < 60)
				s = prev_sample;
			else if (pick < 75)
				s = (sb.white > 0) ? $urandom_range(0, sb.white - 1) : 0;
			else
				s = $urandom_range(0, 4095);
			if (s < 0) s = 0;
			if (s > 4095) s = 4095;
			pick = $urandom_range(99);
			if (pick < 10)
				d = '0;
			else if (pick < 30)
				d = DT_W'($urandom_range(1, 200));
			else if (pick < 85)
				d = DT_W'($urandom_range(1000, 100000));
			else if (pick < 95)
				d = DT_W'($urandom_range(0, 16777215));
			else
				d = '1;
			send_sample(s, d);
		end
	endtask

	initial begin
		#TIMEOUT_UNITS;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed items under the reset setup
		send_sample(700, 24'd0);        // first item ignores elapsed time
		send_sample(0, 24'hFFFFFF);
		send_sample(4095, 24'd0);       // rising crossing with zero elapsed time
		send_sample(4095, 24'd0);       // no change in error
		send_sample(4095, 24'd1);
		send_sample(100, 24'd1);
		for (int i = 0; i < 10; i++)
			send_sample(0, 24'd5000);   // white run, ramp saturates
		send_sample(299, 24'd5000);
		send_sample(300, 24'd5000);
		send_sample(800, 24'd20000);    // crossing up from white
		send_sample(699, 24'd10000);
		send_sample(701, 24'd0);
		send_sample(650, 24'd1000);
		send_sample(2048, 24'd12345);
		send_sample(1365, 24'hAAAAAA);
		send_sample(2730, 24'h555555);
		drain();

		for (int k = 0; k < SETUP_COUNT; k++) begin
			if (k < 4) begin
				src_idle_pct = 38;
				sink_stall_pct = 72;
			end else if (k < 7) begin
				src_idle_pct = 72;
				sink_stall_pct = 38;
			end else begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			load_setup(k);
			play_random(ITEMS_PER_SETUP);
			drain();
		end

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
